### rtl/pda_pkg.sv
package pda_pkg;

  localparam int COORD_WIDTH_DEF  = 20;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int GUARD_BITS     = 20;
  localparam int TABLE_LEN      = 24;
  localparam int Z_WIDTH        = 34;
  localparam int INV_GAIN_WIDTH = 31;
  localparam int DIST_WIDTH     = 21;
  localparam int ANGLE_WIDTH    = 16;
  localparam int ANGLE_MAX      = 25736;
  localparam int ANGLE_SHIFT    = 17;
  localparam int DIST_SHIFT     = 31;

  localparam logic signed [Z_WIDTH-1:0] PI_Z = 34'sd3373259426;
  localparam logic [INV_GAIN_WIDTH-1:0] INV_GAIN = 31'd1304065748;
  localparam logic [DIST_WIDTH-1:0] DIST_MAX = '1;

  // atan(2^-i) in units of 2^-30 rad
  function automatic logic signed [Z_WIDTH-1:0] atan_z(input int i);
    logic signed [Z_WIDTH-1:0] r;
    case (i)
      0:       r = 34'sd843314857;
      1:       r = 34'sd497837829;
      2:       r = 34'sd263043837;
      3:       r = 34'sd133525159;
      4:       r = 34'sd67021687;
      5:       r = 34'sd33543516;
      6:       r = 34'sd16775851;
      7:       r = 34'sd8388437;
      8:       r = 34'sd4194283;
      9:       r = 34'sd2097149;
      10:      r = 34'sd1048576;
      11:      r = 34'sd524288;
      12:      r = 34'sd262144;
      13:      r = 34'sd131072;
      14:      r = 34'sd65536;
      15:      r = 34'sd32768;
      16:      r = 34'sd16384;
      17:      r = 34'sd8192;
      18:      r = 34'sd4096;
      19:      r = 34'sd2048;
      20:      r = 34'sd1024;
      21:      r = 34'sd512;
      22:      r = 34'sd256;
      23:      r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/point_distance_and_angle.sv
// Stages from input request to result: one pre-rotation stage, one stage per CORDIC
//   micro-rotation, a gain multiply stage and a rounding stage that is also the
//   output register.
// Throughput: one request per cycle; an output stall freezes the whole pipeline.
// Reset clears the stage valid bits only; datapath registers are not reset.
module point_distance_and_angle #(
  parameter int COORD_WIDTH  = pda_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = pda_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]         from_x_i,
  input  logic signed [COORD_WIDTH-1:0]         from_y_i,
  input  logic signed [COORD_WIDTH-1:0]         to_x_i,
  input  logic signed [COORD_WIDTH-1:0]         to_y_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [pda_pkg::DIST_WIDTH-1:0]        distance_o,
  output logic signed [pda_pkg::ANGLE_WIDTH-1:0] angle_o
);
  import pda_pkg::*;

  localparam int DW  = COORD_WIDTH + 1;
  localparam int XW  = COORD_WIDTH + GUARD_BITS + 3;
  localparam int XIW = XW - 1 - GUARD_BITS;
  localparam int PIW = XIW + INV_GAIN_WIDTH;
  localparam int PFW = GUARD_BITS + INV_GAIN_WIDTH;
  localparam int TW  = PIW + 1;
  localparam int RW  = TW + DIST_WIDTH;
  localparam int NS  = CORDIC_STEPS + 3;
  localparam int MS  = CORDIC_STEPS + 1;
  localparam int OS  = CORDIC_STEPS + 2;

  logic          adv;
  logic [NS-1:0] vld_q;
  logic [NS-1:0] zero_q;

  logic signed [XW-1:0]      x_q [CORDIC_STEPS+1];
  logic signed [XW-1:0]      y_q [CORDIC_STEPS+1];
  logic signed [Z_WIDTH-1:0] z_q [CORDIC_STEPS+1];

  assign adv        = !vld_q[OS] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // pre-rotation: difference, negate dy, fold left half plane
  logic signed [DW-1:0]      dx, ny;
  logic signed [XW-1:0]      x0_d, y0_d;
  logic signed [Z_WIDTH-1:0] z0_d;
  logic                      zero_d;

  always_comb begin
    dx     = DW'(to_x_i) - DW'(from_x_i);
    ny     = DW'(from_y_i) - DW'(to_y_i);
    zero_d = (dx == '0) && (ny == '0);
    x0_d   = XW'(dx) <<< GUARD_BITS;
    y0_d   = XW'(ny) <<< GUARD_BITS;
    z0_d   = '0;
    if (dx[DW-1]) begin
      x0_d = -x0_d;
      y0_d = -y0_d;
      z0_d = (!ny[DW-1] && ny != '0) ? PI_Z : -PI_Z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero_q <= {zero_q[NS-2:0], zero_d};
      x_q[0] <= x0_d;
      y_q[0] <= y0_d;
      z_q[0] <= z0_d;
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    logic signed [XW-1:0] xs, ys;
    assign xs = x_q[g] >>> g;
    assign ys = y_q[g] >>> g;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!y_q[g][XW-1]) begin
          x_q[g+1] <= x_q[g] + ys;
          y_q[g+1] <= y_q[g] - xs;
          z_q[g+1] <= z_q[g] + atan_z(g);
        end else begin
          x_q[g+1] <= x_q[g] - ys;
          y_q[g+1] <= y_q[g] + xs;
          z_q[g+1] <= z_q[g] - atan_z(g);
        end
      end
    end
  end

  // gain removal products
  logic [XW-2:0]             ux;
  logic [PIW-1:0]            prod_i_q;
  logic [PFW-1:0]            prod_f_q;
  logic signed [Z_WIDTH-1:0] z_m_q;

  assign ux = x_q[CORDIC_STEPS][XW-1] ? '0 : x_q[CORDIC_STEPS][XW-2:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_i_q <= PIW'(ux[XW-2:GUARD_BITS]) * PIW'(INV_GAIN);
      prod_f_q <= PFW'(ux[GUARD_BITS-1:0]) * PFW'(INV_GAIN);
      z_m_q    <= z_q[CORDIC_STEPS];
    end
  end

  // rounding, saturation and zero result for coincident points
  logic [TW-1:0]             total;
  logic [RW-1:0]             rnd;
  logic [RW-1:0]             dist_full;
  logic signed [Z_WIDTH:0]   zr, ang_full;
  logic [DIST_WIDTH-1:0]     dist_d;
  logic signed [ANGLE_WIDTH-1:0] ang_d;
  logic [DIST_WIDTH-1:0]     dist_q;
  logic signed [ANGLE_WIDTH-1:0] ang_q;

  always_comb begin
    total     = TW'(prod_i_q) + TW'(prod_f_q >> GUARD_BITS);
    rnd       = RW'(total) + (RW'(1) << (DIST_SHIFT - 1));
    dist_full = rnd >> DIST_SHIFT;
    dist_d    = (dist_full > RW'(DIST_MAX)) ? DIST_MAX : dist_full[DIST_WIDTH-1:0];
    zr        = (Z_WIDTH+1)'(z_m_q) + ((Z_WIDTH+1)'(1) <<< (ANGLE_SHIFT - 1));
    ang_full  = zr >>> ANGLE_SHIFT;
    if (ang_full > (Z_WIDTH+1)'(ANGLE_MAX)) begin
      ang_d = ANGLE_WIDTH'(ANGLE_MAX);
    end else if (ang_full < -(Z_WIDTH+1)'(ANGLE_MAX)) begin
      ang_d = -ANGLE_WIDTH'(ANGLE_MAX);
    end else begin
      ang_d = ang_full[ANGLE_WIDTH-1:0];
    end
    if (zero_q[MS]) begin
      dist_d = '0;
      ang_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q <= dist_d;
      ang_q  <= ang_d;
    end
  end

  assign out_valid_o = vld_q[OS];
  assign distance_o  = dist_q;
  assign angle_o     = ang_q;

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  a_request_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted request lost at pipeline entry");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(angle_o) <= ANGLE_MAX && $signed(angle_o) >= -ANGLE_MAX))
    else $error("angle outside +-pi");

endmodule

### sim/tb_point_distance_and_angle.sv
package tb_pda_pkg;

  localparam int COORD_W = pda_pkg::COORD_WIDTH_DEF;
  localparam int STEPS   = pda_pkg::CORDIC_STEPS_DEF;
  localparam int DIST_W  = pda_pkg::DIST_WIDTH;
  localparam int ANGLE_W = pda_pkg::ANGLE_WIDTH;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]         dist_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  typedef struct packed {
    dist_t  distance;
    angle_t angle;
  } polar_t;

  localparam int              FRAC_GUARD   = 20;
  localparam longint          HALF_TURN    = 64'sd3373259426;
  localparam longint unsigned RECIP_GAIN   = 64'd1304065748;
  localparam longint          ANGLE_LIMIT  = 25736;
  localparam longint unsigned DIST_LIMIT   = 64'h1F_FFFF;

  // atan(2^-i) scaled by 2^30
  localparam longint ATAN_Q30 [24] = '{
    843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437,
    4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048,
    1024, 512, 256, 128
  };

  class polar_scoreboard;
    polar_t      pending[$];
    int unsigned n_requests;
    int unsigned n_results;
    int unsigned mismatches;

    static function polar_t to_polar(coord_t fx, coord_t fy, coord_t tx, coord_t ty);
      longint          dx, ny, x, y, z, xs, ys, a;
      longint unsigned ux, xi, xf, total, dist_v;
      polar_t          r;
      r  = '0;
      dx = longint'(tx) - longint'(fx);
      ny = longint'(fy) - longint'(ty);
      if (dx == 0 && ny == 0) begin
        return r;
      end
      x = dx <<< FRAC_GUARD;
      y = ny <<< FRAC_GUARD;
      z = 0;
      // left half plane: pre-rotate by pi
      if (dx < 0) begin
        z = (ny > 0) ? HALF_TURN : -HALF_TURN;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys;
          y -= xs;
          z += ATAN_Q30[i];
        end else begin
          x -= ys;
          y += xs;
          z -= ATAN_Q30[i];
        end
      end
      ux     = (x > 0) ? $unsigned(x) : 64'd0;
      xi     = ux >> FRAC_GUARD;
      xf     = ux & ((64'd1 << FRAC_GUARD) - 64'd1);
      total  = xi * RECIP_GAIN + ((xf * RECIP_GAIN) >> FRAC_GUARD);
      dist_v = (total + (64'd1 << 30)) >> 31;
      if (dist_v > DIST_LIMIT) begin
        dist_v = DIST_LIMIT;
      end
      a = (z + 65536) >>> 17;
      if (a > ANGLE_LIMIT) begin
        a = ANGLE_LIMIT;
      end
      if (a < -ANGLE_LIMIT) begin
        a = -ANGLE_LIMIT;
      end
      r.distance = dist_v[DIST_W-1:0];
      r.angle    = a[ANGLE_W-1:0];
      return r;
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 50) begin
        $display("MISMATCH result %0d: %s", n_results, what);
      end
    endtask

    function void note_request(coord_t fx, coord_t fy, coord_t tx, coord_t ty);
      pending.push_back(to_polar(fx, fy, tx, ty));
      n_requests++;
    endfunction

    task check_result(dist_t got_dist, angle_t got_angle);
      polar_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result dist=%0d angle=%0d", got_dist, got_angle));
      end else begin
        want = pending.pop_front();
        if (got_dist !== want.distance) begin
          report($sformatf("distance %0d, want %0d", got_dist, want.distance));
        end
        if (got_angle !== want.angle) begin
          report($sformatf("angle %0d, want %0d", got_angle, $signed(want.angle)));
        end
      end
      n_results++;
    endtask
  endclass

endpackage

module tb_point_distance_and_angle;
  timeunit 1ns;
  timeprecision 1ps;

  import tb_pda_pkg::*;

  localparam int     LATENCY    = STEPS + 3;
  localparam int     HOLD_LEN   = 100;
  localparam int     N_RANDOM   = 430;
  localparam int     LIMIT      = 200000;
  localparam coord_t CMIN       = coord_t'(-524288);
  localparam coord_t CMAX       = coord_t'(524287);

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   out_ready_i = 1'b0;
  coord_t from_x_i    = '0;
  coord_t from_y_i    = '0;
  coord_t to_x_i      = '0;
  coord_t to_y_i      = '0;
  logic   in_ready_o;
  logic   out_valid_o;
  dist_t  distance_o;
  angle_t angle_o;

  polar_scoreboard sb = new();
  bit              tx_burst = 1'b0;
  int unsigned     n_sent = 0;
  int unsigned     n_directed;
  int unsigned     cycles = 0;

  point_distance_and_angle #(
    .COORD_WIDTH (COORD_W),
    .CORDIC_STEPS(STEPS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .from_x_i   (from_x_i),
    .from_y_i   (from_y_i),
    .to_x_i     (to_x_i),
    .to_y_i     (to_y_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .distance_o (distance_o),
    .angle_o    (angle_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles,
               sb.pending.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // all drives are nonblocking, so these reads see pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_request(from_x_i, from_y_i, to_x_i, to_y_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result(distance_o, angle_o);
      end
    end
  end

  task automatic send_request(input coord_t fx, input coord_t fy,
                              input coord_t tx, input coord_t ty);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    from_x_i   <= fx;
    from_y_i   <= fy;
    to_x_i     <= tx;
    to_y_i     <= ty;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  task automatic send_random();
    coord_t fx, fy, tx, ty;
    int unsigned kind;
    fx   = coord_t'($urandom);
    fy   = coord_t'($urandom);
    tx   = coord_t'($urandom);
    ty   = coord_t'($urandom);
    kind = $urandom_range(0, 9);
    case (kind)
      4, 5: begin
        tx = fx + coord_t'($urandom_range(0, 64)) - coord_t'(32);
        ty = fy + coord_t'($urandom_range(0, 64)) - coord_t'(32);
      end
      6: begin
        tx = fx;
        ty = fy;
      end
      7: ty = fy;
      8: tx = fx;
      9: ty = fy + (($urandom_range(0, 1) == 1) ? coord_t'(1) : coord_t'(-1));
      default: ;
    endcase
    send_request(fx, fy, tx, ty);
  endtask

  // result side: random stalls, bursts with none, two long hold-offs
  initial begin : result_sink
    int unsigned gap;
    int unsigned n_taken;
    n_taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (n_taken == 30 || n_taken == 250) begin
        gap = HOLD_LEN;
      end else if ((n_taken / 50) % 4 == 1) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 5);
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      n_taken++;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // coincident points
    send_request(0, 0, 0, 0);
    send_request(CMAX, CMAX, CMAX, CMAX);
    send_request(CMIN, CMIN, CMIN, CMIN);
    // axes, both directions, unit and larger steps
    send_request(0, 0, 16, 0);
    send_request(0, 0, -16, 0);
    send_request(0, 0, 0, -16);
    send_request(0, 0, 0, 16);
    send_request(0, 0, 1, 0);
    send_request(0, 0, -1, 0);
    send_request(0, 0, 0, 1);
    send_request(0, 0, 0, -1);
    send_request(0, 0, -1, -1);
    send_request(0, 0, -1, 1);
    // extreme differences on every diagonal
    send_request(CMIN, CMIN, CMAX, CMAX);
    send_request(CMAX, CMAX, CMIN, CMIN);
    send_request(CMIN, CMAX, CMAX, CMIN);
    send_request(CMAX, CMIN, CMIN, CMAX);
    // far left horizontal and just off it, where the angle may pass pi
    send_request(CMAX, 0, CMIN, 0);
    send_request(CMAX, 0, CMIN, 1);
    send_request(CMAX, 0, CMIN, -1);
    send_request(CMIN, 0, CMAX, 0);
    send_request(0, CMIN, 0, CMAX);
    send_request(0, CMAX, 0, CMIN);
    send_request(0, 0, 1, CMAX);
    n_directed = n_sent;

    for (int n = 0; n < N_RANDOM; n++) begin
      tx_burst = ((n / 40) % 4 == 3);
      send_random();
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (3 * LATENCY) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    end

    $display("covered %0d requests (%0d directed: axes, extremes, coincident, near pi),",
             sb.n_requests, n_directed);
    $display("checked %0d results; output held off twice for %0d cycles, %0d mismatches",
             sb.n_results, HOLD_LEN, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
